FILE: src/tbp_pkg.sv
// Shared types, constants and helpers for the tournament branch predictor.
package tbp_pkg;

  // Default table sizes, powers of two
  localparam int BIMODAL_ENTRIES_DEF = 1024;
  localparam int GSHARE_ENTRIES_DEF  = 4096;
  localparam int CHOOSER_ENTRIES_DEF = 4096;

  // Program counter bits that any table of up to 65536 entries can use
  localparam int IDX_W = 16;

  // Global history width and the part of it kept before each shift
  localparam int HIST_W      = 7;
  localparam int HIST_KEEP_W = 5;

  // Counter width and the value every table entry starts from
  localparam int           CTR_W    = 2;
  localparam logic [1:0]   CTR_INIT = 2'd2;
  localparam logic [1:0]   CTR_MAX  = 2'd3;
  localparam logic [1:0]   CTR_MIN  = 2'd0;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [CTR_W-1:0] tbp_ctr_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } tbp_in_t;

  typedef struct packed {
    logic chose_gshare;
    logic predicted_taken;
    logic mispredicted;
  } tbp_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             taken;
  } tbp_item_t;

  // Saturating 2-bit counter step
  function automatic tbp_ctr_t sat_move(input tbp_ctr_t ctr, input logic up);
    tbp_ctr_t res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

FILE: src/tbp_front.sv
// Input stage: accepts branch transactions and reduces them to table index bits.
module tbp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbp_pkg::tbp_in_t   in_data,
  output logic               item_valid,
  input  logic               item_ready,
  output tbp_pkg::tbp_item_t item_data
);
  import tbp_pkg::*;

  logic      valid_r, valid_nxt;
  tbp_item_t item_r, item_nxt;
  logic      in_fire;

  // Take a new transaction when the slot is empty or drains this cycle
  assign in_ready = !valid_r || item_ready;
  assign in_fire  = in_valid && in_ready;

  // Keep only the low pc bits that index the tables
  always_comb begin
    item_nxt       = item_r;
    item_nxt.idx   = in_data.pc[IDX_W-1:0];
    item_nxt.taken = in_data.taken;
    valid_nxt      = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item_data  = item_r;

endmodule

FILE: src/tbp_queue.sv
// Short FIFO that decouples the input stage from the table stage.
module tbp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  tbp_pkg::tbp_item_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output tbp_pkg::tbp_item_t pop_data
);
  import tbp_pkg::*;

  tbp_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/tbp_back.sv
// Table stage: chooser, bimodal and gshare tables, update logic and result register.
module tbp_back #(
  parameter int BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF,
  parameter int GSHARE_ENTRIES  = tbp_pkg::GSHARE_ENTRIES_DEF,
  parameter int CHOOSER_ENTRIES = tbp_pkg::CHOOSER_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  tbp_pkg::tbp_item_t item_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbp_pkg::tbp_out_t  out_data
);
  import tbp_pkg::*;

  localparam int BI_W  = $clog2(BIMODAL_ENTRIES);
  localparam int GS_W  = $clog2(GSHARE_ENTRIES);
  localparam int CH_W  = $clog2(CHOOSER_ENTRIES);
  localparam int CLR_N = (BIMODAL_ENTRIES > GSHARE_ENTRIES)
                         ? ((BIMODAL_ENTRIES > CHOOSER_ENTRIES) ? BIMODAL_ENTRIES
                                                                : CHOOSER_ENTRIES)
                         : ((GSHARE_ENTRIES > CHOOSER_ENTRIES) ? GSHARE_ENTRIES
                                                               : CHOOSER_ENTRIES);
  localparam int CLR_W = $clog2(CLR_N);

  // Table storage
  tbp_ctr_t bi_mem [BIMODAL_ENTRIES];
  tbp_ctr_t gs_mem [GSHARE_ENTRIES];
  tbp_ctr_t ch_mem [CHOOSER_ENTRIES];

  // Clearing pass after reset
  logic             clr_active_r, clr_active_nxt;
  logic [CLR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             clr_bi, clr_gs, clr_ch;

  // Lookup stage: item whose table reads are registered
  logic            r_valid_r, r_valid_nxt;
  logic            r_taken_r;
  logic [BI_W-1:0] r_bi_idx_r;
  logic [GS_W-1:0] r_gs_idx_r;
  logic [CH_W-1:0] r_ch_idx_r;
  tbp_ctr_t        bi_rd_r, gs_rd_r, ch_rd_r;
  logic            bi_fwd_r, gs_fwd_r, ch_fwd_r;
  tbp_ctr_t        bi_fwd_val_r, gs_fwd_val_r, ch_fwd_val_r;

  // History
  logic [HIST_W-1:0] hist_r, hist_nxt;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  tbp_out_t out_data_r, out_data_nxt;

  // Execute-side values
  logic     exec, issue;
  tbp_ctr_t bi_val, gs_val, ch_val;
  logic     use_gs, pred, miss;
  tbp_ctr_t bi_upd, gs_upd, ch_upd;

  // Read addresses for the item entering the lookup stage
  logic [BI_W-1:0] bi_raddr;
  logic [GS_W-1:0] gs_raddr;
  logic [CH_W-1:0] ch_raddr;

  // Write ports
  logic            bi_we, gs_we, ch_we;
  logic [BI_W-1:0] bi_waddr;
  logic [GS_W-1:0] gs_waddr;
  logic [CH_W-1:0] ch_waddr;
  tbp_ctr_t        bi_wdata, gs_wdata, ch_wdata;

  // Handshake between stages
  assign exec       = r_valid_r && (!out_valid_r || out_ready);
  assign item_ready = !clr_active_r && (!r_valid_r || exec);
  assign issue      = item_valid && item_ready;

  // Resolve read data, taking the same-cycle write where it hit
  assign bi_val = bi_fwd_r ? bi_fwd_val_r : bi_rd_r;
  assign gs_val = gs_fwd_r ? gs_fwd_val_r : gs_rd_r;
  assign ch_val = ch_fwd_r ? ch_fwd_val_r : ch_rd_r;

  // Choose, predict and train
  always_comb begin
    use_gs = ch_val[1];
    pred   = use_gs ? gs_val[1] : bi_val[1];
    miss   = pred ^ r_taken_r;
    bi_upd = sat_move(bi_val, r_taken_r);
    gs_upd = sat_move(gs_val, r_taken_r);
    ch_upd = sat_move(ch_val, use_gs ? !miss : miss);
  end

  // Shift history only when gshare made the call
  always_comb begin
    hist_nxt = hist_r;
    if (exec && use_gs) begin
      hist_nxt = {hist_r[HIST_KEEP_W-1:0], 1'b0, r_taken_r};
    end
  end

  // Index the next item with the history it will see
  assign bi_raddr = item_data.idx[BI_W-1:0];
  assign ch_raddr = item_data.idx[CH_W-1:0];
  assign gs_raddr = item_data.idx[GS_W-1:0] ^ GS_W'(hist_nxt);

  // Sweep all tables to the initial counter value
  assign clr_bi = clr_active_r && ({1'b0, clr_idx_r} < (CLR_W + 1)'(BIMODAL_ENTRIES));
  assign clr_gs = clr_active_r && ({1'b0, clr_idx_r} < (CLR_W + 1)'(GSHARE_ENTRIES));
  assign clr_ch = clr_active_r && ({1'b0, clr_idx_r} < (CLR_W + 1)'(CHOOSER_ENTRIES));

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    if (clr_active_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == CLR_W'(CLR_N - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  // Write port select: clearing pass or trained counter
  always_comb begin
    bi_we    = clr_active_r ? clr_bi : (exec && !use_gs);
    gs_we    = clr_active_r ? clr_gs : (exec && use_gs);
    ch_we    = clr_active_r ? clr_ch : exec;
    bi_waddr = clr_active_r ? clr_idx_r[BI_W-1:0] : r_bi_idx_r;
    gs_waddr = clr_active_r ? clr_idx_r[GS_W-1:0] : r_gs_idx_r;
    ch_waddr = clr_active_r ? clr_idx_r[CH_W-1:0] : r_ch_idx_r;
    bi_wdata = clr_active_r ? CTR_INIT : bi_upd;
    gs_wdata = clr_active_r ? CTR_INIT : gs_upd;
    ch_wdata = clr_active_r ? CTR_INIT : ch_upd;
  end

  // Bimodal table
  always_ff @(posedge clk) begin
    if (bi_we) begin
      bi_mem[bi_waddr] <= bi_wdata;
    end
    if (issue) begin
      bi_rd_r <= bi_mem[bi_raddr];
    end
  end

  // Gshare table
  always_ff @(posedge clk) begin
    if (gs_we) begin
      gs_mem[gs_waddr] <= gs_wdata;
    end
    if (issue) begin
      gs_rd_r <= gs_mem[gs_raddr];
    end
  end

  // Chooser table
  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    if (issue) begin
      ch_rd_r <= ch_mem[ch_raddr];
    end
  end

  // Capture lookup payload and same-cycle write hits
  always_ff @(posedge clk) begin
    if (issue) begin
      r_taken_r    <= item_data.taken;
      r_bi_idx_r   <= bi_raddr;
      r_gs_idx_r   <= gs_raddr;
      r_ch_idx_r   <= ch_raddr;
      bi_fwd_r     <= bi_we && (bi_waddr == bi_raddr);
      gs_fwd_r     <= gs_we && (gs_waddr == gs_raddr);
      ch_fwd_r     <= ch_we && (ch_waddr == ch_raddr);
      bi_fwd_val_r <= bi_wdata;
      gs_fwd_val_r <= gs_wdata;
      ch_fwd_val_r <= ch_wdata;
    end
  end

  // Stage valid and result register
  always_comb begin
    r_valid_nxt = r_valid_r;
    if (issue) begin
      r_valid_nxt = 1'b1;
    end else if (exec) begin
      r_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    out_data_nxt.chose_gshare    = use_gs;
    out_data_nxt.predicted_taken = pred;
    out_data_nxt.mispredicted    = miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      r_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      hist_r       <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
      r_valid_r    <= r_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      hist_r       <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // No item enters the lookup stage while the tables are being cleared
  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !issue)
    else $error("item issued during clearing pass");

  // Bit 1 of the history is never set by a shift
  a_hist_bit1_zero: assert property (@(posedge clk) disable iff (!rst_n)
    exec && use_gs |=> hist_r[1] == 1'b0)
    else $error("history bit 1 set");

  // A bimodal decision leaves the history alone
  a_hist_hold_bimodal: assert property (@(posedge clk) disable iff (!rst_n)
    exec && !use_gs |=> $stable(hist_r))
    else $error("history changed on bimodal decision");

  // A result is produced only from an occupied lookup stage into a free result slot
  a_exec_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> r_valid_r && !clr_active_r && (!out_valid_r || out_ready))
    else $error("execute without a valid lookup");
`endif

endmodule

FILE: src/tournament_branch_predictor.sv
// Tournament branch predictor: top level joining input stage, queue and table stage.
//
// Each transaction is one resolved branch (pc, taken); the block answers with the
// component picked by the chooser, its prediction and whether it missed, then trains
// that component, the chooser and (on gshare use) the 7-bit global history. Table
// sizes must be powers of two; indexes are the low pc bits, for gshare xored with
// the history. After reset the block runs a clearing pass over max(BIMODAL_ENTRIES,
// GSHARE_ENTRIES, CHOOSER_ENTRIES) entries (4096 at the default sizes) before the
// first branch reaches the tables; up to three branches are taken into the input
// register and queue meanwhile, then in_ready stays low until the pass ends. After
// that it sustains one branch per cycle while out_ready stays high: each table does
// one registered read and one write per cycle, and a write that hits the address read
// in the same cycle is forwarded. From input to result a branch passes the input
// register, the queue, the table read and the result register.
module tournament_branch_predictor #(
  parameter int BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF,
  parameter int GSHARE_ENTRIES  = tbp_pkg::GSHARE_ENTRIES_DEF,
  parameter int CHOOSER_ENTRIES = tbp_pkg::CHOOSER_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tbp_pkg::tbp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tbp_pkg::tbp_out_t out_data
);
  import tbp_pkg::*;

  logic      fr_valid, fr_ready;
  tbp_item_t fr_item;
  logic      q_valid, q_ready;
  tbp_item_t q_item;

  // Accept and classify
  tbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item_data  (fr_item)
  );

  // Decouple front and back
  tbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_item)
  );

  // Predict and train
  tbp_back #(
    .BIMODAL_ENTRIES (BIMODAL_ENTRIES),
    .GSHARE_ENTRIES  (GSHARE_ENTRIES),
    .CHOOSER_ENTRIES (CHOOSER_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item_data  (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
